>>> hdl/bpl_pkg.sv
`default_nettype none

package bpl_pkg;

    localparam int ENTRY_W = 32;
    localparam int POS_W   = 6;
    localparam int CAP_W   = 6;
    localparam int CNT_W   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_VIEW   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_VIEW = 1'b1
    } t_back_state;

    // Command as handed from the front part to the back part.
    typedef struct packed {
        t_op                      op;
        logic                     pos_zero;
        logic [POS_W-1:0]         pos_m1;
        logic signed [ENTRY_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [ENTRY_W-1:0] entry;
        logic [CNT_W-1:0]          entry_count;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/bpl_fifo.sv
`default_nettype none

module bpl_fifo #(
    parameter type t_item = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_data,
    output logic       o_empty
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

`default_nettype wire

>>> hdl/bpl_front.sv
`default_nettype none

module bpl_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [bpl_pkg::POS_W-1:0] i_position,
    input  wire logic signed [bpl_pkg::ENTRY_W-1:0] i_value,
    output logic                          o_cmd_valid,
    input  wire logic                     i_cmd_pop,
    output bpl_pkg::t_cmd                 o_cmd
);

    bpl_pkg::t_cmd w_cmd;
    logic          w_empty;

    // Positions are turned into 0-based indexes here; a zero position is
    // flagged so the back part never has to look at the wrapped index.
    always_comb begin
        w_cmd.op       = bpl_pkg::t_op'(i_opcode);
        w_cmd.pos_zero = (i_position == '0);
        w_cmd.pos_m1   = i_position - bpl_pkg::POS_W'(1);
        w_cmd.value    = i_value;
    end

    bpl_fifo #(
        .t_item (bpl_pkg::t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

`default_nettype wire

>>> hdl/bpl_back.sv
`default_nettype none

module bpl_back #(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [bpl_pkg::CAP_W-1:0] i_cfg_capacity,
    input  wire logic                      i_cmd_valid,
    output logic                           o_cmd_pop,
    input  wire bpl_pkg::t_cmd             i_cmd,
    output bpl_pkg::t_result               o_res,
    output logic                           o_empty,
    input  wire logic                      i_pop
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > bpl_pkg::POS_W) ? CW : bpl_pkg::POS_W) + 1;

    logic signed [bpl_pkg::ENTRY_W-1:0] r_entries [DEPTH];
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [CW-1:0]                 r_left;
    logic [CW-1:0]                 n_left;
    logic [bpl_pkg::CAP_W-1:0]     r_capacity;
    bpl_pkg::t_back_state          r_state;
    bpl_pkg::t_back_state          n_state;
    bpl_pkg::t_result              w_res;
    logic                          w_out_push;
    logic                          w_out_full;
    logic                          w_ins;
    logic                          w_del;
    logic                          w_rot;
    logic [XW-1:0]                 w_count_x;
    logic [XW-1:0]                 w_idx_x;
    logic                          w_is_full;

    assign w_count_x = XW'(r_count);
    assign w_idx_x   = XW'(i_cmd.pos_m1);
    assign w_is_full = (w_count_x >= XW'(r_capacity)) || (w_count_x >= XW'(DEPTH));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        o_cmd_pop   = 1'b0;
        w_out_push  = 1'b0;
        w_ins       = 1'b0;
        w_del       = 1'b0;
        w_rot       = 1'b0;
        w_res.status      = bpl_pkg::ST_OK;
        w_res.entry       = '0;
        w_res.last        = 1'b1;
        unique case (r_state)
            bpl_pkg::BK_IDLE: begin
                if (i_cmd_valid && !w_out_full) begin
                    o_cmd_pop  = 1'b1;
                    w_out_push = 1'b1;
                    unique case (i_cmd.op)
                        bpl_pkg::OP_INSERT: begin
                            if (w_is_full) begin
                                w_res.status = bpl_pkg::ST_FULL;
                            end else if (i_cmd.pos_zero || w_idx_x > w_count_x) begin
                                w_res.status = bpl_pkg::ST_BADPOS;
                            end else begin
                                w_ins   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bpl_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                w_res.status = bpl_pkg::ST_EMPTY;
                            end else if (i_cmd.pos_zero || w_idx_x >= w_count_x) begin
                                w_res.status = bpl_pkg::ST_BADPOS;
                            end else begin
                                w_del   = 1'b1;
                                n_count = r_count - CW'(1);
                            end
                        end
                        bpl_pkg::OP_VIEW: begin
                            if (r_count == '0) begin
                                w_res.status = bpl_pkg::ST_EMPTY;
                            end else begin
                                // The entries go out one per cycle from the view state if results have room.
                                w_out_push = 1'b0;
                                n_left     = r_count;
                                n_state    = bpl_pkg::BK_VIEW;
                            end
                        end
                        bpl_pkg::OP_CLEAR: begin
                            if (r_count == '0) begin
                                w_res.status = bpl_pkg::ST_EMPTY;
                            end else begin
                                n_count = '0;
                            end
                        end
                        default: begin
                            w_res.status = bpl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bpl_pkg::BK_VIEW: begin
                if (!w_out_full) begin
                    // The head entry is sent and the occupied part of the list
                    // rotates by one, so after count steps it is back in order.
                    w_out_push  = 1'b1;
                    w_rot       = 1'b1;
                    w_res.entry = r_entries[0];
                    w_res.last  = (r_left == CW'(1));
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = bpl_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = bpl_pkg::BK_IDLE;
            end
        endcase
        w_res.entry_count = bpl_pkg::CNT_W'(n_count);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [bpl_pkg::ENTRY_W-1:0] w_prev;
        logic signed [bpl_pkg::ENTRY_W-1:0] w_next;
        logic signed [bpl_pkg::ENTRY_W-1:0] w_d;
        logic                          w_we;

        if (g > 0) begin : g_has_prev
            assign w_prev = r_entries[g-1];
        end else begin : g_no_prev
            assign w_prev = '0;
        end
        if (g < DEPTH - 1) begin : g_has_next
            assign w_next = r_entries[g+1];
        end else begin : g_no_next
            assign w_next = '0;
        end

        always_comb begin
            w_we = 1'b0;
            w_d  = w_next;
            if (w_ins) begin
                if (XW'(g) == w_idx_x) begin
                    w_we = 1'b1;
                    w_d  = i_cmd.value;
                end else if (XW'(g) > w_idx_x && XW'(g) <= w_count_x) begin
                    w_we = 1'b1;
                    w_d  = w_prev;
                end
            end else if (w_del) begin
                if (XW'(g) >= w_idx_x && XW'(g) + XW'(1) < w_count_x) begin
                    w_we = 1'b1;
                end
            end else if (w_rot) begin
                if (XW'(g) + XW'(1) < w_count_x) begin
                    w_we = 1'b1;
                end else if (XW'(g) + XW'(1) == w_count_x) begin
                    w_we = 1'b1;
                    w_d  = r_entries[0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_entries[g] <= w_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bpl_pkg::BK_IDLE;
            r_count    <= '0;
            r_left     <= '0;
            r_capacity <= bpl_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
            end
        end
    end

    bpl_fifo #(
        .t_item (bpl_pkg::t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

>>> hdl/bounded_positional_list_core.sv
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------
// command   | in        | push / full         | i_opcode, i_position, i_value
// result    | out       | empty / pop         | o_status, o_entry, o_entry_count, o_last
// capacity  | in        | i_cfg_valid / ready | i_cfg_capacity
//
// Insert, delete and clear are done in the list unit's idle state; a view enters
// a view state that sends one entry per cycle, set by the single head read.
// A two-item command queue and a two-item result queue let both sides stall
// independently; a full result queue stalls the list unit.
// Reset is synchronous and empties the list; capacity returns to 32.

module bounded_positional_list_core #(
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [5:0]                 i_position,
    input  wire logic signed [31:0]         i_value,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [1:0]                      o_status,
    output logic signed [31:0]              o_entry,
    output logic [5:0]                      o_entry_count,
    output logic                            o_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [5:0]                 i_cfg_capacity
);

    bpl_pkg::t_cmd    w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_pop;
    bpl_pkg::t_result w_res;

    assign o_cfg_ready = 1'b1;

    bpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    bpl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_pop      (w_cmd_pop),
        .i_cmd          (w_cmd),
        .o_res          (w_res),
        .o_empty        (empty),
        .i_pop          (pop)
    );

    assign o_status      = w_res.status;
    assign o_entry       = w_res.entry;
    assign o_entry_count = w_res.entry_count;
    assign o_last        = w_res.last;

endmodule

`default_nettype wire

>>> hdl/bpl_checker.sv
`default_nettype none

module bpl_checker #(
    parameter int DEPTH = 32
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [1:0]         o_status,
    input wire logic signed [31:0] o_entry,
    input wire logic [5:0]         o_entry_count,
    input wire logic               o_last
);

    // The result queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // An error or empty report is always a single final result with no entry.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != bpl_pkg::ST_OK) |-> (o_last && o_entry == '0))
        else $error("non-ok result carries an entry or is not last");

    // An empty status means the list holds nothing.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == bpl_pkg::ST_EMPTY) |-> (o_entry_count == '0))
        else $error("empty status with nonzero entry count");

    // The count never exceeds the storage depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (7'(o_entry_count) <= 7'(DEPTH)))
        else $error("entry count beyond depth");

    // A result that is not taken stays on the ports.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_entry) && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind bounded_positional_list_core bpl_checker #(
    .DEPTH (DEPTH)
) u_bpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_status      (o_status),
    .o_entry       (o_entry),
    .o_entry_count (o_entry_count),
    .o_last        (o_last)
);

`default_nettype wire
